// ===== rtl/keyframe_linear_interpolator_core_macros.svh =====
// Assertion macros used by the keyframe interpolator RTL.
`ifndef KEYFRAME_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define KEYFRAME_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

// Antecedent true implies consequent true in the same cycle.
`define KLI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent true implies consequent true in the next cycle.
`define KLI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kli_pkg.sv =====
// ----------------------------------------------------------------------------
// kli_pkg
// Types and constants for the keyframe linear interpolator.
// ----------------------------------------------------------------------------
package kli_pkg;

    localparam int DATA_W        = 32;
    localparam int MAX_KEYS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        MODE_QUERY  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_STATIC = 2'd2,
        MODE_RSVD   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_INTERP = 3'd0,
        ST_HELD   = 3'd1,
        ST_STATIC = 3'd2,
        ST_DONE   = 3'd3,
        ST_FULL   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        RES_ZERO   = 2'd0,
        RES_STATIC = 2'd1,
        RES_RD     = 2'd2,
        RES_LERP   = 2'd3
    } res_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRD,
        S_QCMP,
        S_DIV,
        S_MUL,
        S_ADD,
        S_IRD,
        S_ICMP,
        S_SHCHK,
        S_SHWR,
        S_INSW,
        S_OUT
    } state_t;

    typedef struct packed {
        logic                     [1:0] mode;
        logic signed [DATA_W-1:0]       item_time;
        logic signed [DATA_W-1:0]       item_value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic        [2:0]        status;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_in;
        logic     set_static;
        logic     rd_en;
        logic     wr_en;
        logic     wr_from_in;
        logic     cap_prev;
        logic     div_init;
        logic     div_step;
        logic     mul_en;
        logic     pend_load;
        res_sel_t pend_sel;
        status_t  pend_status;
        logic     out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic gt;
        logic ge;
        logic out_busy;
    } sts_t;

endpackage

// ===== rtl/kli_datapath.sv =====
// ----------------------------------------------------------------------------
// kli_datapath
// Keyframe tables, divider, multiplier and result registers.
// ----------------------------------------------------------------------------
module kli_datapath
    import kli_pkg::*;
#(
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  in_item_t        in_data,
    input  cmd_t            cmd,
    input  logic [AW-1:0]   rd_addr,
    input  logic [AW-1:0]   wr_addr,
    output sts_t            sts,
    input  logic            out_ready,
    output logic            out_valid,
    output out_item_t       out_data
);

    localparam int PW = DATA_W + 2 + FRAC_BITS;

    logic signed [DATA_W-1:0] key_times  [MAX_KEYS];
    logic signed [DATA_W-1:0] key_values [MAX_KEYS];

    in_item_t                 in_reg;
    logic signed [DATA_W-1:0] static_reg;
    logic signed [DATA_W-1:0] rd_t_reg, rd_v_reg, prev_t_reg, prev_v_reg;
    logic        [DATA_W-1:0] rem_reg, den_reg;
    logic        [FRAC_BITS-1:0] quo_reg;
    logic signed [DATA_W:0]   dv_reg;
    logic signed [PW-1:0]     prod_reg;
    logic signed [DATA_W-1:0] pend_val_reg;
    status_t                  pend_st_reg;
    out_item_t                out_reg;
    logic                     out_valid_reg;

    logic signed [DATA_W:0]   dt_w, dd_w, dv_w;
    logic        [DATA_W:0]   rem2;
    logic signed [PW-1:0]     prod_w, shifted, sum_w;
    logic signed [DATA_W-1:0] lerp_val, pend_val_next;

    // Differences against the previous keyframe
    always_comb
    begin
        dt_w = {in_reg.item_time[DATA_W-1], in_reg.item_time} - {prev_t_reg[DATA_W-1], prev_t_reg};
        dd_w = {rd_t_reg[DATA_W-1], rd_t_reg} - {prev_t_reg[DATA_W-1], prev_t_reg};
        dv_w = {rd_v_reg[DATA_W-1], rd_v_reg} - {prev_v_reg[DATA_W-1], prev_v_reg};
        rem2 = {rem_reg, 1'b0};
    end

    // Interpolated value: v0 + floor(dv * frac / 2^F)
    always_comb
    begin
        prod_w   = dv_reg * $signed({1'b0, quo_reg});
        shifted  = prod_reg >>> FRAC_BITS;
        sum_w    = {{(PW-DATA_W){prev_v_reg[DATA_W-1]}}, prev_v_reg} + shifted;
        lerp_val = sum_w[DATA_W-1:0];
    end

    always_comb
    begin
        case (cmd.pend_sel)
            RES_ZERO:   pend_val_next = '0;
            RES_STATIC: pend_val_next = static_reg;
            RES_RD:     pend_val_next = rd_v_reg;
            RES_LERP:   pend_val_next = lerp_val;
            default:    pend_val_next = '0;
        endcase
    end

    // Table storage, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            key_times[wr_addr]  <= cmd.wr_from_in ? in_reg.item_time  : rd_t_reg;
            key_values[wr_addr] <= cmd.wr_from_in ? in_reg.item_value : rd_v_reg;
        end
        if (cmd.rd_en)
        begin
            rd_t_reg <= key_times[rd_addr];
            rd_v_reg <= key_values[rd_addr];
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_data;
        if (cmd.cap_prev)
        begin
            prev_t_reg <= rd_t_reg;
            prev_v_reg <= rd_v_reg;
        end
        if (cmd.div_init)
        begin
            rem_reg <= dt_w[DATA_W-1:0];
            den_reg <= dd_w[DATA_W-1:0];
            dv_reg  <= dv_w;
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem2 >= {1'b0, den_reg})
            begin
                rem_reg <= rem2[DATA_W-1:0] - den_reg;
                quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[DATA_W-1:0];
                quo_reg <= {quo_reg[FRAC_BITS-2:0], 1'b0};
            end
        end
        if (cmd.mul_en)
            prod_reg <= prod_w;
        if (cmd.pend_load)
        begin
            pend_val_reg <= pend_val_next;
            pend_st_reg  <= cmd.pend_status;
        end
        if (cmd.out_load)
        begin
            out_reg.result_value <= pend_val_reg;
            out_reg.status       <= pend_st_reg;
        end
    end

    // Static level and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            static_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_static)
                static_reg <= in_data.item_value;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign sts.gt       = rd_t_reg >  in_reg.item_time;
    assign sts.ge       = rd_t_reg >= in_reg.item_time;
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;
    assign out_data     = out_reg;

endmodule

// ===== rtl/kli_controller.sv =====
// ----------------------------------------------------------------------------
// kli_controller
// Sequencer for search, shift-insert, divide and result hand-off.
// ----------------------------------------------------------------------------
module kli_controller
    import kli_pkg::*;
#(
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int CW = $clog2(MAX_KEYS + 1),
    localparam int SW = $clog2(FRAC_BITS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_mode,
    input  sts_t          sts,
    output cmd_t          cmd,
    output logic [AW-1:0] rd_addr,
    output logic [AW-1:0] wr_addr,
    output state_t        state
);

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  pos_reg, pos_next;
    logic [SW-1:0]  step_reg, step_next;
    logic [CW-1:0]  idx_m1;
    logic           accept;

    assign idx_m1 = idx_reg - CW'(1);
    assign accept = in_valid && (state_reg == S_IDLE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            pos_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            pos_reg   <= pos_next;
            step_reg  <= step_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        step_next  = step_reg;
        cmd        = '0;
        rd_addr    = idx_reg[AW-1:0];
        wr_addr    = idx_reg[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_in = 1'b1;
                    idx_next    = '0;
                    case (mode_t'(in_mode))
                        MODE_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                cmd.pend_load   = 1'b1;
                                cmd.pend_sel    = RES_STATIC;
                                cmd.pend_status = ST_STATIC;
                                state_next      = S_OUT;
                            end
                            else
                                state_next = S_QRD;
                        end
                        MODE_INSERT:
                        begin
                            if (count_reg == CW'(MAX_KEYS))
                            begin
                                cmd.pend_load   = 1'b1;
                                cmd.pend_sel    = RES_ZERO;
                                cmd.pend_status = ST_FULL;
                                state_next      = S_OUT;
                            end
                            else if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_INSW;
                            end
                            else
                                state_next = S_IRD;
                        end
                        MODE_STATIC:
                        begin
                            cmd.set_static  = 1'b1;
                            count_next      = '0;
                            cmd.pend_load   = 1'b1;
                            cmd.pend_sel    = RES_ZERO;
                            cmd.pend_status = ST_DONE;
                            state_next      = S_OUT;
                        end
                        default:
                        begin
                            cmd.pend_load   = 1'b1;
                            cmd.pend_sel    = RES_ZERO;
                            cmd.pend_status = ST_FULL;
                            state_next      = S_OUT;
                        end
                    endcase
                end
            end

            // Query: first key later than the time
            S_QRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_QCMP;
            end
            S_QCMP:
            begin
                if (sts.gt)
                begin
                    if (idx_reg == '0)
                    begin
                        cmd.pend_load   = 1'b1;
                        cmd.pend_sel    = RES_RD;
                        cmd.pend_status = ST_HELD;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        cmd.div_init = 1'b1;
                        step_next    = '0;
                        state_next   = S_DIV;
                    end
                end
                else
                begin
                    cmd.cap_prev = 1'b1;
                    if (idx_reg == count_reg - CW'(1))
                    begin
                        cmd.pend_load   = 1'b1;
                        cmd.pend_sel    = RES_RD;
                        cmd.pend_status = ST_HELD;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + CW'(1);
                        state_next = S_QRD;
                    end
                end
            end

            // One quotient bit per cycle
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + SW'(1);
                if (step_reg == SW'(FRAC_BITS - 1))
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_ADD;
            end
            S_ADD:
            begin
                cmd.pend_load   = 1'b1;
                cmd.pend_sel    = RES_LERP;
                cmd.pend_status = ST_INTERP;
                state_next      = S_OUT;
            end

            // Insert: first key not earlier than the time
            S_IRD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ICMP;
            end
            S_ICMP:
            begin
                if (sts.ge)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHCHK;
                end
                else if (idx_reg == count_reg - CW'(1))
                begin
                    pos_next   = count_reg;
                    idx_next   = count_reg;
                    state_next = S_SHCHK;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_IRD;
                end
            end

            // Move entries up by one, top first
            S_SHCHK:
            begin
                if (idx_reg == pos_reg)
                    state_next = S_INSW;
                else
                begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = idx_m1[AW-1:0];
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.wr_en  = 1'b1;
                idx_next   = idx_m1;
                state_next = S_SHCHK;
            end
            S_INSW:
            begin
                cmd.wr_en       = 1'b1;
                cmd.wr_from_in  = 1'b1;
                wr_addr         = pos_reg[AW-1:0];
                count_next      = count_reg + CW'(1);
                cmd.pend_load   = 1'b1;
                cmd.pend_sel    = RES_ZERO;
                cmd.pend_status = ST_DONE;
                state_next      = S_OUT;
            end

            // Hand result to the output register once it is free
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);
    assign state    = state_reg;

endmodule

// ===== rtl/keyframe_linear_interpolator_core.sv =====
// ----------------------------------------------------------------------------
// keyframe_linear_interpolator_core
// Sorted keyframe table with piecewise linear interpolation in signed Q16.16.
//
//   channel | direction | type       | handshake
//   in      | input     | in_item_t  | in_valid / in_ready
//   out     | output    | out_item_t | out_valid / out_ready
//
// A query reads and compares each key scanned, then divides to FRAC_BITS
// quotient bits, multiplies and adds; the single-port table read sets the
// scan cost. An insert scans the same way, then moves each key up with a
// read and a write. Set-static, full-table and reserved skip to the output.
// Reset clears the key count, static level and handshake state; no sweep.
// One transaction is in flight at a time; a result waiting in the output
// register does not block acceptance of the next transaction.
// ----------------------------------------------------------------------------
`include "keyframe_linear_interpolator_core_macros.svh"

module keyframe_linear_interpolator_core
    import kli_pkg::*;
#(
    parameter int MAX_KEYS  = MAX_KEYS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    cmd_t          cmd;
    sts_t          sts;
    logic [AW-1:0] rd_addr, wr_addr;
    state_t        state;

    kli_controller #(
        .MAX_KEYS  (MAX_KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_mode  (in_data.mode),
        .sts      (sts),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .state    (state)
    );

    kli_datapath #(
        .MAX_KEYS  (MAX_KEYS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .sts       (sts),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Checks
    `KLI_ASSERT_NOW(a_no_write_idle, clk, rst_n, cmd.wr_en, state != S_IDLE, "table write while idle")
    `KLI_ASSERT_NOW(a_out_slot_free, clk, rst_n, cmd.out_load, !(out_valid && !out_ready), "result overwrites pending output")
    `KLI_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready, "second transaction accepted while busy")

endmodule
